// ===== rtl/core/utf8_pkg.sv =====
// Package with the payload types, constants and sequencer states of the UTF-8 decoder.
package utf8_pkg;

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        malformed;
      logic        run_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEAD,
      ST_CONT,
      ST_DONE
   } seq_state_type;

endpackage

// ===== rtl/core/utf8_codepoint_decoder.sv =====
// Streaming UTF-8 decoder that gives code points and U+FFFD for malformed bytes.
// An item holds the decoder through acceptance and a finishing step, one step per lead byte
// and one per continuation byte walked, and one closing check unless the walk ends on a
// short sequence; output stalls can hold it longer. req_stall is high from the cycle after
// acceptance until the last result moves to the output register. Reset is synchronous,
// active high, and clears sequencer and count.
module utf8_codepoint_decoder
   import utf8_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   seq_state_type   state_ff, state_in;
   logic [7:0]      q_ff [4];
   logic [7:0]      q_in [4];
   logic [2:0]      cnt_ff, cnt_in;
   logic [2:0]      m_ff, m_in;
   logic [2:0]      p_ff, p_in;
   logic [1:0]      idx_ff, idx_in;
   logic [1:0]      left_ff, left_in;
   logic            last_ff, last_in;
   logic [20:0]     cp_ff, cp_in;
   logic            hold_valid_ff, hold_valid_in;
   logic [20:0]     hold_cp_ff, hold_cp_in;
   logic            hold_bad_ff, hold_bad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Shared byte decoder signals.
   logic [7:0]  b0;
   logic [7:0]  bc;
   logic        is_ascii;
   logic        is_lead;
   logic [1:0]  extra;
   logic [20:0] lead_bits;
   logic        too_short;
   logic        cont_ok;
   logic        at_end;
   logic        req_acc;
   logic        out_free;
   logic        can_emit;
   logic        emit_req;
   logic        emit_fire;
   logic [20:0] emit_cp;
   logic        emit_bad;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit = !hold_valid_ff || out_free;
   assign at_end   = (p_ff == m_ff);

   always_comb begin
      b0 = q_ff[p_ff[1:0]];
      bc = q_ff[idx_ff];
      is_ascii  = !b0[7];
      is_lead   = 1'b1;
      extra     = 2'd1;
      lead_bits = '0;
      priority if (b0[7:5] == 3'b110) begin
         extra     = 2'd1;
         lead_bits = {16'd0, b0[4:0]};
      end else if (b0[7:4] == 4'b1110) begin
         extra     = 2'd2;
         lead_bits = {17'd0, b0[3:0]};
      end else if (b0[7:3] == 5'b11110) begin
         extra     = 2'd3;
         lead_bits = {18'd0, b0[2:0]};
      end else begin
         is_lead = 1'b0;
      end
      too_short = ({1'b0, p_ff} + 4'd1 + {2'b00, extra}) > {1'b0, m_ff};
      cont_ok   = (bc[7:6] == 2'b10);
   end

   // Result requests from the current sequencer step.
   always_comb begin
      emit_req = 1'b0;
      emit_cp  = REPLACEMENT_CP;
      emit_bad = 1'b1;
      unique case (state_ff)
         ST_LEAD: begin
            if (!at_end) begin
               if (is_ascii) begin
                  emit_req = 1'b1;
                  emit_cp  = {13'd0, b0};
                  emit_bad = 1'b0;
               end else if (!is_lead) begin
                  emit_req = 1'b1;
               end else if (too_short && last_ff) begin
                  emit_req = 1'b1;
               end
            end
         end
         ST_CONT: begin
            if (!cont_ok) begin
               emit_req = 1'b1;
            end else if (left_ff == 2'd1) begin
               emit_req = 1'b1;
               emit_cp  = {cp_ff[14:0], bc[5:0]};
               emit_bad = 1'b0;
            end
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
      emit_fire = emit_req && can_emit;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_LEAD;
         end
         ST_LEAD: begin
            if (at_end) begin
               state_in = ST_DONE;
            end else if (is_ascii || !is_lead) begin
               state_in = ST_LEAD;
            end else if (too_short) begin
               if (!last_ff || can_emit) state_in = ST_DONE;
            end else begin
               state_in = ST_CONT;
            end
         end
         ST_CONT: begin
            if (emit_fire) state_in = ST_LEAD;
         end
         ST_DONE: begin
            if (!hold_valid_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      last_in       = last_ff;
      cp_in         = cp_ff;
      hold_valid_in = hold_valid_ff;
      hold_cp_in    = hold_cp_ff;
      hold_bad_in   = hold_bad_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (emit_fire) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{code_point: hold_cp_ff, malformed: hold_bad_ff, run_end: 1'b0};
         end
         hold_valid_in = 1'b1;
         hold_cp_in    = emit_cp;
         hold_bad_in   = emit_bad;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               q_in[cnt_ff[1:0]] = req_data.text_byte;
               m_in    = cnt_ff + 3'd1;
               p_in    = '0;
               last_in = req_data.final_byte;
               cnt_in  = '0;
            end
         end
         ST_LEAD: begin
            if (!at_end) begin
               if (is_ascii || !is_lead) begin
                  if (emit_fire) p_in = p_ff + 3'd1;
               end else if (too_short) begin
                  if (!last_ff) begin
                     // Keep the unfinished sequence at the front for the next item.
                     for (int i = 0; i < 4; i++) begin
                        q_in[i] = q_ff[2'(i) + p_ff[1:0]];
                     end
                     cnt_in = m_ff - p_ff;
                     p_in   = m_ff;
                  end else if (emit_fire) begin
                     p_in = m_ff;
                  end
               end else begin
                  cp_in   = lead_bits;
                  idx_in  = p_ff[1:0] + 2'd1;
                  left_in = extra;
               end
            end
         end
         ST_CONT: begin
            if (!cont_ok) begin
               // Restart at the byte after the lead so buffered bytes replay.
               if (emit_fire) p_in = p_ff + 3'd1;
            end else if (left_ff == 2'd1) begin
               if (emit_fire) p_in = {1'b0, idx_ff} + 3'd1;
            end else begin
               cp_in   = {cp_ff[14:0], bc[5:0]};
               idx_in  = idx_ff + 2'd1;
               left_in = left_ff - 2'd1;
            end
         end
         ST_DONE: begin
            if (hold_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '{code_point: hold_cp_ff, malformed: hold_bad_ff, run_end: 1'b1};
               hold_valid_in = 1'b0;
            end
         end
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      m_ff        <= m_in;
      p_ff        <= p_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      last_ff     <= last_in;
      cp_ff       <= cp_in;
      hold_cp_ff  <= hold_cp_in;
      hold_bad_ff <= hold_bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_no_held_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("held result left behind when the item finished");

   a_buffer_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd3)
      else $error("buffered byte count out of range");

   a_position_in_queue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAD || state_ff == ST_CONT) |-> p_ff <= m_ff && m_ff <= 3'd4)
      else $error("decode position beyond the queued bytes");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && hold_valid_ff) |=> rsp_valid_ff)
      else $error("held result dropped instead of moved to the output");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming UTF-8 code point decoder.
`timescale 1ns / 1ps

module tb;
   import utf8_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 360;
   localparam int REPORT_LIMIT = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   // Copy of the decoder state: the bytes of an unfinished sequence.
   logic [7:0]  held_bytes [4];
   int unsigned held_count = 0;

   rsp_payload_type expected_cps[$];
   int unsigned     mismatch_count = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     cycle_count = 0;

   // Idle controls for the sender and for the result stall process.
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned stall_left = 0;
   int unsigned hold_off_cycles = 0;

   utf8_codepoint_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic rsp_payload_type codepoint_item(input logic [20:0] cp, input logic bad);
      rsp_payload_type item;
      item.code_point = cp;
      item.malformed  = bad;
      item.run_end    = 1'b0;
      return item;
   endfunction

   // Works out the code points that one accepted byte releases.
   task automatic predict_codepoints(input req_payload_type item);
      logic [7:0]      seq_bytes [4];
      rsp_payload_type found [4];
      int unsigned     total;
      int unsigned     pos;
      int unsigned     extra;
      int unsigned     idx;
      int unsigned     n_found;
      logic [7:0]      lead;
      logic [20:0]     cp;
      bit              ok;
      bit              done;
      total = 0;
      n_found = 0;
      pos = 0;
      done = 1'b0;
      cp = '0;
      for (idx = 0; idx < held_count && idx < 3; idx++) begin
         seq_bytes[total] = held_bytes[idx];
         total++;
      end
      seq_bytes[total] = item.text_byte;
      total++;
      held_count = 0;
      while (pos < total && !done) begin
         lead = seq_bytes[pos];
         extra = 0;
         if (lead[7:5] == 3'b110) begin
            extra = 1;
            cp = {16'b0, lead[4:0]};
         end else if (lead[7:4] == 4'b1110) begin
            extra = 2;
            cp = {17'b0, lead[3:0]};
         end else if (lead[7:3] == 5'b11110) begin
            extra = 3;
            cp = {18'b0, lead[2:0]};
         end
         if (lead[7] == 1'b0) begin
            found[n_found] = codepoint_item({13'b0, lead}, 1'b0);
            n_found++;
            pos++;
         end else if (extra == 0) begin
            found[n_found] = codepoint_item(REPLACEMENT_CP, 1'b1);
            n_found++;
            pos++;
         end else if (pos + 1 + extra > total) begin
            // Sequence is incomplete: it is either cut off by the end of text or kept.
            if (item.final_byte) begin
               found[n_found] = codepoint_item(REPLACEMENT_CP, 1'b1);
               n_found++;
            end else begin
               for (idx = pos; idx < total; idx++)
                  held_bytes[idx - pos] = seq_bytes[idx];
               held_count = total - pos;
            end
            done = 1'b1;
         end else begin
            ok = 1'b1;
            for (idx = 1; idx <= extra; idx++) begin
               if (seq_bytes[pos + idx][7:6] != 2'b10)
                  ok = 1'b0;
               else
                  cp = (cp << 6) | {15'b0, seq_bytes[pos + idx][5:0]};
            end
            if (ok) begin
               found[n_found] = codepoint_item(cp, 1'b0);
               pos += 1 + extra;
            end else begin
               // Bad continuation: restart right after the lead and replay the rest.
               found[n_found] = codepoint_item(REPLACEMENT_CP, 1'b1);
               pos++;
            end
            n_found++;
         end
      end
      if (n_found > 0)
         found[n_found - 1].run_end = 1'b1;
      for (idx = 0; idx < n_found; idx++)
         expected_cps.insert(expected_cps.size(), found[idx]);
   endtask

   task automatic send_byte(input logic [7:0] value, input bit last_of_text);
      req_payload_type item;
      int unsigned     gap;
      item.text_byte  = value;
      item.final_byte = last_of_text;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_codepoints(item);
      bytes_sent++;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         gap = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input logic [7:0] text[$]);
      int unsigned idx;
      for (idx = 0; idx < text.size(); idx++)
         send_byte(text[idx], idx == text.size() - 1);
   endtask

   // The sender goes quiet so that no accepted item is offered a second time.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_cps.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] continuation_byte();
      logic [5:0] bits;
      bits = 6'($urandom);
      return {2'b10, bits};
   endfunction

   // Builds one text, now and then of random bytes, else mostly well-formed characters with a few broken ones.
   task automatic build_text(output logic [7:0] text[$]);
      int unsigned n_chars;
      int unsigned kind;
      int unsigned n_cont;
      int unsigned idx;
      logic [7:0]  junk;
      text = {};
      n_chars = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
      if ($urandom_range(9) == 0) begin
         for (idx = 0; idx < n_chars; idx++)
            text.insert(text.size(), 8'($urandom));
         return;
      end
      for (idx = 0; idx < n_chars; idx++) begin
         kind = $urandom_range(99);
         n_cont = 0;
         if (kind < 30) begin
            text.insert(text.size(), 8'($urandom_range(127)));
         end else if (kind < 87) begin
            if (kind < 50) begin
               text.insert(text.size(), {3'b110, 5'($urandom)});
               n_cont = 1;
            end else if (kind < 65) begin
               text.insert(text.size(), {4'b1110, 4'($urandom)});
               n_cont = 2;
            end else begin
               text.insert(text.size(), {5'b11110, 3'($urandom)});
               n_cont = 3;
            end
            repeat (n_cont) text.insert(text.size(), continuation_byte());
         end else if (kind < 93) begin
            if ($urandom_range(1) == 0)
               text.insert(text.size(), {2'b10, 6'($urandom)});
            else
               text.insert(text.size(), {5'b11111, 3'($urandom)});
         end else begin
            // Multi-byte character with one continuation spoiled or cut short.
            n_cont = $urandom_range(3, 1);
            text.insert(text.size(), (n_cont == 1) ? {3'b110, 5'($urandom)} :
                                     (n_cont == 2) ? {4'b1110, 4'($urandom)} :
                                                     {5'b11110, 3'($urandom)});
            if ($urandom_range(1) == 0) begin
               junk = 8'($urandom);
               if (junk[7:6] == 2'b10)
                  junk[6] = 1'b1;
               repeat ($urandom_range(n_cont - 1))
                  text.insert(text.size(), continuation_byte());
               text.insert(text.size(), junk);
            end else begin
               repeat ($urandom_range(n_cont - 1))
                  text.insert(text.size(), continuation_byte());
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_codepoints
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected item: code_point=%h malformed=%b run_end=%b",
                        rsp_data.code_point, rsp_data.malformed, rsp_data.run_end);
         end else begin
            want = expected_cps.pop_front();
            if (rsp_data.code_point !== want.code_point ||
                rsp_data.malformed !== want.malformed ||
                rsp_data.run_end !== want.run_end) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Mismatch: expected %h/%b/%b, got %h/%b/%b",
                           want.code_point, want.malformed, want.run_end,
                           rsp_data.code_point, rsp_data.malformed, rsp_data.run_end);
            end
         end
      end
   end

   task automatic test_directed_bytes();
      gap_pct = 0;
      stall_pct = 0;
      // ASCII extremes.
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      // Complete sequences of two, three and four bytes, the last one the largest value.
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      // Stray continuation byte and a lead of five ones.
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
      // Text ends in the middle of a sequence.
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      // Bad continuation whose replayed bytes decode as plain ASCII.
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      // Bad continuation that replays a shorter sequence.
      send_byte(8'hF0, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'h41, 1'b1);
      // Bad continuation whose replay stays buffered until the next item.
      send_byte(8'hE1, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b1);
   endtask

   task automatic test_random_texts();
      logic [7:0]  text[$];
      int unsigned stop_at;
      int unsigned phase;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 20; stall_pct = 30; end
            1: begin gap_pct = 0;  stall_pct = 0;  end
            2: begin gap_pct = 50; stall_pct = 60; end
            default: begin gap_pct = 5; stall_pct = 10; end
         endcase
         stop_at = bytes_sent + RANDOM_ITEMS / 4;
         while (bytes_sent < stop_at) begin
            build_text(text);
            send_text(text);
         end
      end
   endtask

   task automatic test_hold_off();
      logic [7:0] text[$];
      gap_pct = 0;
      stall_pct = 0;
      wait_drained();
      // The receiver stalls for a long stretch while the sender keeps offering items.
      hold_off_cycles = 200;
      repeat (3) begin
         build_text(text);
         send_text(text);
      end
      wait_drained();
   endtask

   task automatic test_drain_pause();
      logic [7:0] text[$];
      gap_pct = 10;
      stall_pct = 20;
      build_text(text);
      send_text(text);
      wait_drained();
      build_text(text);
      send_text(text);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_bytes();
      test_random_texts();
      test_hold_off();
      test_drain_pause();
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && expected_cps.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
